// ===== sv/dns_query_name_hash_parser_core_assert.svh =====
// ----------------------------------------------------------------------------
// DNS query name hash parser - assertion macros
// Shared macros for the concurrent checks of the parser.
// ----------------------------------------------------------------------------
`ifndef DNS_QUERY_NAME_HASH_PARSER_CORE_ASSERT_SVH
`define DNS_QUERY_NAME_HASH_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define DNSQH_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dnsqh check failed");

// Next-cycle implication, disabled while reset is held.
`define DNSQH_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dnsqh check failed");

`endif

// ===== sv/dnsqh_pkg.sv =====
// ----------------------------------------------------------------------------
// DNS query name hash parser - package
// Shared constants, result codes and result item layout.
// ----------------------------------------------------------------------------
`default_nettype none

package dnsqh_pkg;

    localparam int DEF_MAX_LENGTH_READS = 10;
    localparam int DEF_HASHED_PREFIX    = 32;

    localparam int LIMIT_W = 12;
    localparam logic [LIMIT_W-1:0] DEF_NAME_LENGTH_LIMIT = 12'd253;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] HASH_MULT = 32'd16777619;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RESPONSE  = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;
    localparam logic [1:0] ST_LIMIT     = 2'd3;

    // anomaly flag bit positions
    localparam int FLAG_ANY_BIT     = 0;
    localparam int FLAG_QDCOUNT_BIT = 1;
    localparam int FLAG_LABELS_BIT  = 2;
    localparam int FLAG_LONG_BIT    = 3;
    localparam int FLAG_OPCODE_BIT  = 4;

    // result tdata layout, lowest bit up
    localparam int STATUS_LSB = 0;
    localparam int HASH_LSB   = 2;
    localparam int QTYPE_LSB  = 34;
    localparam int FLAGS_LSB  = 50;
    localparam int RES_BITS   = 55;
    localparam int M_DATA_W   = 56;

    typedef struct packed {
        logic [4:0]  anomaly_flags;
        logic [15:0] query_type;
        logic [31:0] name_hash;
        logic [1:0]  status;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/dns_query_name_hash_parser_core.sv =====
// ----------------------------------------------------------------------------
// DNS query name hash parser - top level
// Walks a DNS query from its header onward, hashes the first HASHED_PREFIX bytes
// of each question label with lowercased FNV-1a 32 and reports status, hash,
// qtype and anomaly flags once per packet on the last byte.
//
//   channel | dir | payload                                   | handshake
//   s_      | in  | data_byte, tlast                          | tvalid/tready
//   m_      | out | status, name_hash, query_type, flags      | tvalid/tready
//   cfg_    | in  | name_length_limit                         | valid/ready
//
// One byte per cycle sustained, unless a last byte must wait; a result item is
// written to the result register from the input register once its last byte is
// processed. The loop through the hash register (xor plus constant multiply)
// sets the cycle time. An input register holds one byte; only a last byte waits
// there, while the result register is still full. Synchronous active-low reset
// returns the parser to the header phase and the length limit to 253.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_query_name_hash_parser_core
    import dnsqh_pkg::*;
#(
    parameter int MAX_LENGTH_READS = DEF_MAX_LENGTH_READS,
    parameter int HASHED_PREFIX    = DEF_HASHED_PREFIX
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [7:0]          s_tdata,   // [7:0] data_byte
    input  wire logic                s_tlast,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,   // [1:0] status, [33:2] name_hash,
                                                // [49:34] query_type,
                                                // [54:50] anomaly_flags, [55] zero
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [LIMIT_W-1:0]  cfg_data   // [11:0] name_length_limit
);

    localparam int LR_W = $clog2(MAX_LENGTH_READS + 1);

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_LENGTH  = 3'd1;
    localparam logic [2:0] PH_LABEL   = 3'd2;
    localparam logic [2:0] PH_TYPE_HI = 3'd3;
    localparam logic [2:0] PH_TYPE_LO = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;
    localparam logic [2:0] PH_FAIL    = 3'd6;

    logic [LIMIT_W-1:0] limit_reg;

    logic               in_valid_reg;
    logic [7:0]         in_data_reg;
    logic               in_last_reg;

    logic [2:0]         phase_reg,      phase_next;
    logic [3:0]         byte_cnt_reg,   byte_cnt_next;
    logic               qr_reg,         qr_next;
    logic               qd_high_reg,    qd_high_next;
    logic [7:0]         remain_reg,     remain_next;
    logic [7:0]         offset_reg,     offset_next;
    logic [LR_W-1:0]    labels_reg,     labels_next;
    logic [LIMIT_W-1:0] len_sum_reg,    len_sum_next;
    logic [31:0]        hash_reg,       hash_next;
    logic [7:0]         type_hi_reg,    type_hi_next;
    logic [15:0]        qtype_reg,      qtype_next;
    logic [4:0]         flags_reg,      flags_next;
    logic [1:0]         outcome_reg,    outcome_next;

    logic               m_valid_reg;
    result_t            m_res_reg;

    logic               out_space;
    logic               proc;
    logic [7:0]         b;
    logic [7:0]         b_lower;
    logic [31:0]        hash_mix;
    logic [LIMIT_W:0]   sum_wide;
    result_t            res;

    assign cfg_ready = 1'b1;
    assign out_space = !m_valid_reg || m_tready;
    assign proc      = in_valid_reg && (!in_last_reg || out_space);
    assign s_tready  = !in_valid_reg || proc;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(M_DATA_W - RES_BITS){1'b0}}, m_res_reg};

    assign b        = in_data_reg;
    assign b_lower  = (b >= 8'h41 && b <= 8'h5A) ? (b | 8'h20) : b;
    assign hash_mix = (hash_reg ^ {24'd0, b_lower}) * HASH_MULT;
    assign sum_wide = {1'b0, len_sum_reg} + {{(LIMIT_W - 7){1'b0}}, b} + 13'd1;

    always_comb begin
        phase_next   = phase_reg;
        byte_cnt_next = byte_cnt_reg;
        qr_next      = qr_reg;
        qd_high_next = qd_high_reg;
        remain_next  = remain_reg;
        offset_next  = offset_reg;
        labels_next  = labels_reg;
        len_sum_next = len_sum_reg;
        hash_next    = hash_reg;
        type_hi_next = type_hi_reg;
        qtype_next   = qtype_reg;
        flags_next   = flags_reg;
        outcome_next = outcome_reg;

        case (phase_reg)
            PH_HEADER: begin
                if (byte_cnt_reg == 4'd2) begin
                    qr_next = b[7];
                    if (b[6:3] != 4'd0) begin
                        flags_next[FLAG_OPCODE_BIT] = 1'b1;
                    end
                end else if (byte_cnt_reg == 4'd4) begin
                    qd_high_next = (b != 8'd0);
                end else if (byte_cnt_reg == 4'd5) begin
                    if (qd_high_reg || b != 8'd1) begin
                        flags_next[FLAG_QDCOUNT_BIT] = 1'b1;
                    end
                end
                if (byte_cnt_reg >= 4'd11) begin
                    if (qr_reg) begin
                        outcome_next = ST_RESPONSE;
                        phase_next   = PH_FAIL;
                    end else begin
                        phase_next = PH_LENGTH;
                    end
                end else begin
                    byte_cnt_next = byte_cnt_reg + 4'd1;
                end
            end
            PH_LENGTH: begin
                if (b == 8'd0) begin
                    phase_next = PH_TYPE_HI;
                end else begin
                    labels_next  = labels_reg + 1'b1;
                    // saturate the length sum
                    len_sum_next = sum_wide[LIMIT_W] ? {LIMIT_W{1'b1}} : sum_wide[LIMIT_W-1:0];
                    remain_next  = b;
                    offset_next  = 8'd0;
                    phase_next   = PH_LABEL;
                end
            end
            PH_LABEL: begin
                if (offset_reg < 8'(HASHED_PREFIX)) begin
                    hash_next = hash_mix;
                end
                offset_next = offset_reg + 8'd1;
                remain_next = remain_reg - 8'd1;
                if (remain_reg == 8'd1) begin
                    if (labels_reg >= LR_W'(MAX_LENGTH_READS)) begin
                        outcome_next = ST_LIMIT;
                        phase_next   = PH_FAIL;
                    end else begin
                        phase_next = PH_LENGTH;
                    end
                end
            end
            PH_TYPE_HI: begin
                type_hi_next = b;
                phase_next   = PH_TYPE_LO;
            end
            PH_TYPE_LO: begin
                qtype_next = {type_hi_reg, b};
                if ({type_hi_reg, b} == 16'd255) begin
                    flags_next[FLAG_ANY_BIT] = 1'b1;
                end
                if (len_sum_reg > limit_reg) begin
                    flags_next[FLAG_LONG_BIT] = 1'b1;
                end
                outcome_next = ST_OK;
                phase_next   = PH_DONE;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        res = '0;
        if (phase_next == PH_DONE) begin
            res.status        = ST_OK;
            res.name_hash     = hash_next;
            res.query_type    = qtype_next;
            res.anomaly_flags = flags_next;
        end else if (phase_next == PH_FAIL) begin
            res.status = outcome_next;
        end else begin
            res.status = ST_TRUNCATED;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= DEF_NAME_LENGTH_LIMIT;
        end else if (cfg_valid && cfg_ready) begin
            limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (proc && in_last_reg)) begin
            // clear per-packet state after the last byte
            phase_reg    <= PH_HEADER;
            byte_cnt_reg <= 4'd0;
            qr_reg       <= 1'b0;
            qd_high_reg  <= 1'b0;
            remain_reg   <= 8'd0;
            offset_reg   <= 8'd0;
            labels_reg   <= '0;
            len_sum_reg  <= '0;
            hash_reg     <= FNV_BASIS;
            type_hi_reg  <= 8'd0;
            qtype_reg    <= 16'd0;
            flags_reg    <= 5'd0;
            outcome_reg  <= ST_TRUNCATED;
        end else if (proc) begin
            phase_reg    <= phase_next;
            byte_cnt_reg <= byte_cnt_next;
            qr_reg       <= qr_next;
            qd_high_reg  <= qd_high_next;
            remain_reg   <= remain_next;
            offset_reg   <= offset_next;
            labels_reg   <= labels_next;
            len_sum_reg  <= len_sum_next;
            hash_reg     <= hash_next;
            type_hi_reg  <= type_hi_next;
            qtype_reg    <= qtype_next;
            flags_reg    <= flags_next;
            outcome_reg  <= outcome_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (proc && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && in_last_reg) begin
            m_res_reg <= res;
        end
    end

endmodule

`default_nettype wire

// ===== sv/dnsqh_checker.sv =====
// ----------------------------------------------------------------------------
// DNS query name hash parser - port checker
// Watches the result channel of the parser and checks its items over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dns_query_name_hash_parser_core_assert.svh"

module dnsqh_checker
    import dnsqh_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata
);

    logic res_failed;
    logic res_payload_zero;
    logic res_spare_clear;

    assign res_failed       = (m_tdata[HASH_LSB-1:STATUS_LSB] != ST_OK);
    assign res_payload_zero = (m_tdata[RES_BITS-1:HASH_LSB] == '0);
    assign res_spare_clear  = !m_tdata[FLAGS_LSB + FLAG_LABELS_BIT] && !m_tdata[M_DATA_W-1];

    // stalled result item holds
    `DNSQH_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // failed packets carry no hash, qtype or flags
    `DNSQH_ASSERT_NOW(a_fail_zero, aclk, aresetn, m_tvalid && res_failed, res_payload_zero)

    // label count flag stays clear and padding stays zero
    `DNSQH_ASSERT_NOW(a_unused_bits, aclk, aresetn, m_tvalid, res_spare_clear)

endmodule

bind dns_query_name_hash_parser_core dnsqh_checker u_dnsqh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
